>>> src/otr_pkg.sv
// Package: token kinds, character codes and decode result type for the operator recognizer.
package otr_pkg;

  typedef enum logic [6:0] {
    TK_TILDE_AMP, TK_TILDE_PIPE, TK_TILDE_CARET, TK_TILDE,
    TK_PLUS_PLUS, TK_PLUS_EQ, TK_PLUS_COLON, TK_PLUS_SLASH_MINUS, TK_PLUS_PERCENT_MINUS,
    TK_PLUS,
    TK_MINUS_MINUS, TK_MINUS_EQ, TK_MINUS_COLON, TK_DASH_GT_GT, TK_ARROW, TK_MINUS,
    TK_POWER, TK_STAR_EQ, TK_STAR_GT, TK_STAR,
    TK_CARET_TILDE, TK_CARET_EQ, TK_CARET,
    TK_AMP3, TK_AMP2, TK_AMP_EQ, TK_AMP,
    TK_PIPE2, TK_PIPE_EQ_GT, TK_PIPE_EQ, TK_PIPE_DASH_GT, TK_PIPE,
    TK_BANG_EQ_EQ, TK_BANG_EQ_Q, TK_BANG_EQ, TK_BANG,
    TK_EQ3, TK_EQ_EQ_Q, TK_EQ2, TK_EQ_GT, TK_EQ,
    TK_HASH2, TK_HASH_MINUS_HASH, TK_HASH_EQ_HASH, TK_HASH,
    TK_DOT_STAR, TK_DOT, TK_COLON2, TK_COLON, TK_AT2, TK_AT,
    TK_SLASH_EQ, TK_SLASH, TK_PERCENT_EQ, TK_PERCENT,
    TK_LT, TK_LT_EQ, TK_LT_DASH_GT, TK_LT3_EQ, TK_LT3, TK_LT2_EQ, TK_LT2,
    TK_GT, TK_GT_EQ, TK_GT3_EQ, TK_GT3, TK_GT2_EQ, TK_GT2,
    TK_ATTR_START, TK_LPAREN, TK_RPAREN, TK_LBRACKET, TK_RBRACKET,
    TK_LBRACE, TK_RBRACE, TK_SEMICOLON, TK_COMMA, TK_QUESTION, TK_ATTR_END,
    TK_ERROR
  } kind_t;

  localparam logic [7:0] CH_LPAREN    = 8'h28;
  localparam logic [7:0] CH_RPAREN    = 8'h29;
  localparam logic [7:0] CH_LBRACKET  = 8'h5B;
  localparam logic [7:0] CH_RBRACKET  = 8'h5D;
  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;
  localparam logic [7:0] CH_SEMICOLON = 8'h3B;
  localparam logic [7:0] CH_COMMA     = 8'h2C;
  localparam logic [7:0] CH_QUESTION  = 8'h3F;
  localparam logic [7:0] CH_TILDE     = 8'h7E;
  localparam logic [7:0] CH_PLUS      = 8'h2B;
  localparam logic [7:0] CH_MINUS     = 8'h2D;
  localparam logic [7:0] CH_STAR      = 8'h2A;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_PERCENT   = 8'h25;
  localparam logic [7:0] CH_CARET     = 8'h5E;
  localparam logic [7:0] CH_AMP       = 8'h26;
  localparam logic [7:0] CH_PIPE      = 8'h7C;
  localparam logic [7:0] CH_BANG      = 8'h21;
  localparam logic [7:0] CH_EQ        = 8'h3D;
  localparam logic [7:0] CH_HASH      = 8'h23;
  localparam logic [7:0] CH_DOT       = 8'h2E;
  localparam logic [7:0] CH_COLON     = 8'h3A;
  localparam logic [7:0] CH_AT        = 8'h40;
  localparam logic [7:0] CH_LT        = 8'h3C;
  localparam logic [7:0] CH_GT        = 8'h3E;

  // Decoder verdict for one window
  typedef struct packed {
    kind_t       kind;
    logic [2:0]  len;
    logic        attr_set;
    logic        attr_clr;
  } dec_t;

endpackage

>>> src/otr_in_if.sv
// Interface: window transfer channel into the recognizer.
interface otr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] first_byte;
  logic [7:0] second_byte;
  logic [7:0] third_byte;
  logic [7:0] fourth_byte;
  logic [2:0] bytes_available;

  modport source (output valid, first_byte, second_byte, third_byte, fourth_byte,
                  bytes_available, input ready);
  modport sink   (input valid, first_byte, second_byte, third_byte, fourth_byte,
                  bytes_available, output ready);
endinterface

>>> src/otr_out_if.sv
// Interface: token transfer channel out of the recognizer.
interface otr_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] token_kind;
  logic [2:0] token_length;

  modport source (output valid, token_kind, token_length, input ready);
  modport sink   (input valid, token_kind, token_length, output ready);
endinterface

>>> src/operator_token_recognizer.sv
// Top level: operator token recognizer with input register, decoder and result register.
// An accepted window is held in the input register, decoded, then its token registered in the result register.
// Throughput: one window per cycle, sustained whenever the sink takes a token each cycle.
// The input and result registers form a two-entry pipeline; each stalls only when full.
// Reset (rst, synchronous, active high): both stages empty and the attribute flag cleared.
module operator_token_recognizer (
  input  logic clk,
  input  logic rst,
  otr_in_if.sink    tok_in,
  otr_out_if.source tok_out
);

  // ---- input register stage ----
  logic       in_full;
  logic [7:0] in_b0;
  logic [7:0] in_b1;
  logic [7:0] in_b2;
  logic [7:0] in_b3;
  logic [2:0] in_avail;

  // ---- result register stage ----
  logic        res_full;
  logic [6:0]  res_kind;
  logic [2:0]  res_len;

  // Attribute state, advanced in window order as each window enters the result stage
  logic attribute_open;

  otr_pkg::dec_t dec;
  logic          advance;   // input stage hands its window to the result stage
  logic          take_in;   // transfer on the input channel

  // Decoder sees the registered window and the current attribute flag.  Because
  // the flag only moves on advance, consecutive windows see it in order.
  otr_decode u_decode (
    .b0        (in_b0),
    .b1        (in_b1),
    .b2        (in_b2),
    .b3        (in_b3),
    .avail     (in_avail),
    .attr_open (attribute_open),
    .dec       (dec)
  );

  assign advance      = in_full && (!res_full || tok_out.ready);
  assign tok_in.ready = !in_full || advance;
  assign take_in      = tok_in.valid && tok_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (take_in) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  // Window payload, no reset needed
  always_ff @(posedge clk) begin
    if (take_in) begin
      in_b0    <= tok_in.first_byte;
      in_b1    <= tok_in.second_byte;
      in_b2    <= tok_in.third_byte;
      in_b3    <= tok_in.fourth_byte;
      in_avail <= tok_in.bytes_available;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_full <= 1'b0;
    end else if (advance) begin
      res_full <= 1'b1;
    end else if (tok_out.ready) begin
      res_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_kind <= 7'(dec.kind);
      res_len  <= dec.len;
    end
  end

  // Open on an attribute start, close on an attribute end; both never fire together
  always_ff @(posedge clk) begin
    if (rst) begin
      attribute_open <= 1'b0;
    end else if (advance && dec.attr_set) begin
      attribute_open <= 1'b1;
    end else if (advance && dec.attr_clr) begin
      attribute_open <= 1'b0;
    end
  end

  assign tok_out.valid        = res_full;
  assign tok_out.token_kind   = res_kind;
  assign tok_out.token_length = res_len;

endmodule

>>> src/otr_decode.sv
// Combinational maximal-munch operator decoder over a four-byte window.
module otr_decode (
  input  logic [7:0]     b0,
  input  logic [7:0]     b1,
  input  logic [7:0]     b2,
  input  logic [7:0]     b3,
  input  logic [2:0]     avail,
  input  logic           attr_open,
  output otr_pkg::dec_t  dec
);

  logic e1, e2, e3;

  // byte p exists when p < clamped count; zero counts as one, above four as four
  assign e1 = (avail >= 3'd2);
  assign e2 = (avail >= 3'd3);
  assign e3 = (avail >= 3'd4);

  function automatic logic has(input logic ex, input logic [7:0] b, input logic [7:0] ch);
    has = ex && (b == ch);
  endfunction

  always_comb begin
    dec.kind     = otr_pkg::TK_ERROR;
    dec.len      = 3'd1;
    dec.attr_set = 1'b0;
    dec.attr_clr = 1'b0;
    case (b0)
      otr_pkg::CH_LPAREN: begin
        if (has(e1, b1, otr_pkg::CH_STAR) && !has(e2, b2, otr_pkg::CH_RPAREN)) begin
          dec.kind = otr_pkg::TK_ATTR_START; dec.len = 3'd2; dec.attr_set = 1'b1;
        end else begin
          dec.kind = otr_pkg::TK_LPAREN;
        end
      end
      otr_pkg::CH_RPAREN:    dec.kind = otr_pkg::TK_RPAREN;
      otr_pkg::CH_LBRACKET:  dec.kind = otr_pkg::TK_LBRACKET;
      otr_pkg::CH_RBRACKET:  dec.kind = otr_pkg::TK_RBRACKET;
      otr_pkg::CH_LBRACE:    dec.kind = otr_pkg::TK_LBRACE;
      otr_pkg::CH_RBRACE:    dec.kind = otr_pkg::TK_RBRACE;
      otr_pkg::CH_SEMICOLON: dec.kind = otr_pkg::TK_SEMICOLON;
      otr_pkg::CH_COMMA:     dec.kind = otr_pkg::TK_COMMA;
      otr_pkg::CH_QUESTION:  dec.kind = otr_pkg::TK_QUESTION;
      otr_pkg::CH_TILDE: begin
        if (has(e1, b1, otr_pkg::CH_AMP)) begin
          dec.kind = otr_pkg::TK_TILDE_AMP; dec.len = 3'd2;
        end else if (has(e1, b1, otr_pkg::CH_PIPE)) begin
          dec.kind = otr_pkg::TK_TILDE_PIPE; dec.len = 3'd2;
        end else if (has(e1, b1, otr_pkg::CH_CARET)) begin
          dec.kind = otr_pkg::TK_TILDE_CARET; dec.len = 3'd2;
        end else begin
          dec.kind = otr_pkg::TK_TILDE;
        end
      end
      otr_pkg::CH_PLUS: begin
        if (has(e1, b1, otr_pkg::CH_PLUS)) begin
          dec.kind = otr_pkg::TK_PLUS_PLUS; dec.len = 3'd2;
        end else if (has(e1, b1, otr_pkg::CH_EQ)) begin
          dec.kind = otr_pkg::TK_PLUS_EQ; dec.len = 3'd2;
        end else if (has(e1, b1, otr_pkg::CH_COLON)) begin
          dec.kind = otr_pkg::TK_PLUS_COLON; dec.len = 3'd2;
        end else if (has(e1, b1, otr_pkg::CH_SLASH) && has(e2, b2, otr_pkg::CH_MINUS)) begin
          dec.kind = otr_pkg::TK_PLUS_SLASH_MINUS; dec.len = 3'd3;
        end else if (has(e1, b1, otr_pkg::CH_PERCENT) && has(e2, b2, otr_pkg::CH_MINUS)) begin
          dec.kind = otr_pkg::TK_PLUS_PERCENT_MINUS; dec.len = 3'd3;
        end else begin
          dec.kind = otr_pkg::TK_PLUS;
        end
      end
      otr_pkg::CH_MINUS: begin
        if (has(e1, b1, otr_pkg::CH_MINUS)) begin
          dec.kind = otr_pkg::TK_MINUS_MINUS; dec.len = 3'd2;
        end else if (has(e1, b1, otr_pkg::CH_EQ)) begin
          dec.kind = otr_pkg::TK_MINUS_EQ; dec.len = 3'd2;
        end else if (has(e1, b1, otr_pkg::CH_COLON)) begin
          dec.kind = otr_pkg::TK_MINUS_COLON; dec.len = 3'd2;
        end else if (has(e1, b1, otr_pkg::CH_GT)) begin
          if (has(e2, b2, otr_pkg::CH_GT)) begin
            dec.kind = otr_pkg::TK_DASH_GT_GT; dec.len = 3'd3;
          end else begin
            dec.kind = otr_pkg::TK_ARROW; dec.len = 3'd2;
          end
        end else begin
          dec.kind = otr_pkg::TK_MINUS;
        end
      end
      otr_pkg::CH_STAR: begin
        if (attr_open && has(e1, b1, otr_pkg::CH_RPAREN)) begin
          dec.kind = otr_pkg::TK_ATTR_END; dec.len = 3'd2; dec.attr_clr = 1'b1;
        end else if (has(e1, b1, otr_pkg::CH_STAR)) begin
          dec.kind = otr_pkg::TK_POWER; dec.len = 3'd2;
        end else if (has(e1, b1, otr_pkg::CH_EQ)) begin
          dec.kind = otr_pkg::TK_STAR_EQ; dec.len = 3'd2;
        end else if (has(e1, b1, otr_pkg::CH_GT)) begin
          dec.kind = otr_pkg::TK_STAR_GT; dec.len = 3'd2;
        end else begin
          dec.kind = otr_pkg::TK_STAR;
        end
      end
      otr_pkg::CH_SLASH: begin
        if (has(e1, b1, otr_pkg::CH_EQ)) begin
          dec.kind = otr_pkg::TK_SLASH_EQ; dec.len = 3'd2;
        end else begin
          dec.kind = otr_pkg::TK_SLASH;
        end
      end
      otr_pkg::CH_PERCENT: begin
        if (has(e1, b1, otr_pkg::CH_EQ)) begin
          dec.kind = otr_pkg::TK_PERCENT_EQ; dec.len = 3'd2;
        end else begin
          dec.kind = otr_pkg::TK_PERCENT;
        end
      end
      otr_pkg::CH_CARET: begin
        if (has(e1, b1, otr_pkg::CH_TILDE)) begin
          dec.kind = otr_pkg::TK_CARET_TILDE; dec.len = 3'd2;
        end else if (has(e1, b1, otr_pkg::CH_EQ)) begin
          dec.kind = otr_pkg::TK_CARET_EQ; dec.len = 3'd2;
        end else begin
          dec.kind = otr_pkg::TK_CARET;
        end
      end
      otr_pkg::CH_AMP: begin
        if (has(e1, b1, otr_pkg::CH_AMP)) begin
          if (has(e2, b2, otr_pkg::CH_AMP)) begin
            dec.kind = otr_pkg::TK_AMP3; dec.len = 3'd3;
          end else begin
            dec.kind = otr_pkg::TK_AMP2; dec.len = 3'd2;
          end
        end else if (has(e1, b1, otr_pkg::CH_EQ)) begin
          dec.kind = otr_pkg::TK_AMP_EQ; dec.len = 3'd2;
        end else begin
          dec.kind = otr_pkg::TK_AMP;
        end
      end
      otr_pkg::CH_PIPE: begin
        if (has(e1, b1, otr_pkg::CH_PIPE)) begin
          dec.kind = otr_pkg::TK_PIPE2; dec.len = 3'd2;
        end else if (has(e1, b1, otr_pkg::CH_EQ)) begin
          if (has(e2, b2, otr_pkg::CH_GT)) begin
            dec.kind = otr_pkg::TK_PIPE_EQ_GT; dec.len = 3'd3;
          end else begin
            dec.kind = otr_pkg::TK_PIPE_EQ; dec.len = 3'd2;
          end
        end else if (has(e1, b1, otr_pkg::CH_MINUS) && has(e2, b2, otr_pkg::CH_GT)) begin
          dec.kind = otr_pkg::TK_PIPE_DASH_GT; dec.len = 3'd3;
        end else begin
          dec.kind = otr_pkg::TK_PIPE;
        end
      end
      otr_pkg::CH_BANG: begin
        if (has(e1, b1, otr_pkg::CH_EQ)) begin
          if (has(e2, b2, otr_pkg::CH_EQ)) begin
            dec.kind = otr_pkg::TK_BANG_EQ_EQ; dec.len = 3'd3;
          end else if (has(e2, b2, otr_pkg::CH_QUESTION)) begin
            dec.kind = otr_pkg::TK_BANG_EQ_Q; dec.len = 3'd3;
          end else begin
            dec.kind = otr_pkg::TK_BANG_EQ; dec.len = 3'd2;
          end
        end else begin
          dec.kind = otr_pkg::TK_BANG;
        end
      end
      otr_pkg::CH_EQ: begin
        if (has(e1, b1, otr_pkg::CH_EQ)) begin
          if (has(e2, b2, otr_pkg::CH_EQ)) begin
            dec.kind = otr_pkg::TK_EQ3; dec.len = 3'd3;
          end else if (has(e2, b2, otr_pkg::CH_QUESTION)) begin
            dec.kind = otr_pkg::TK_EQ_EQ_Q; dec.len = 3'd3;
          end else begin
            dec.kind = otr_pkg::TK_EQ2; dec.len = 3'd2;
          end
        end else if (has(e1, b1, otr_pkg::CH_GT)) begin
          dec.kind = otr_pkg::TK_EQ_GT; dec.len = 3'd2;
        end else begin
          dec.kind = otr_pkg::TK_EQ;
        end
      end
      otr_pkg::CH_HASH: begin
        if (has(e1, b1, otr_pkg::CH_HASH)) begin
          dec.kind = otr_pkg::TK_HASH2; dec.len = 3'd2;
        end else if (has(e1, b1, otr_pkg::CH_MINUS) && has(e2, b2, otr_pkg::CH_HASH)) begin
          dec.kind = otr_pkg::TK_HASH_MINUS_HASH; dec.len = 3'd3;
        end else if (has(e1, b1, otr_pkg::CH_EQ) && has(e2, b2, otr_pkg::CH_HASH)) begin
          dec.kind = otr_pkg::TK_HASH_EQ_HASH; dec.len = 3'd3;
        end else begin
          dec.kind = otr_pkg::TK_HASH;
        end
      end
      otr_pkg::CH_DOT: begin
        if (has(e1, b1, otr_pkg::CH_STAR)) begin
          dec.kind = otr_pkg::TK_DOT_STAR; dec.len = 3'd2;
        end else begin
          dec.kind = otr_pkg::TK_DOT;
        end
      end
      otr_pkg::CH_COLON: begin
        if (has(e1, b1, otr_pkg::CH_COLON)) begin
          dec.kind = otr_pkg::TK_COLON2; dec.len = 3'd2;
        end else begin
          dec.kind = otr_pkg::TK_COLON;
        end
      end
      otr_pkg::CH_AT: begin
        if (has(e1, b1, otr_pkg::CH_AT)) begin
          dec.kind = otr_pkg::TK_AT2; dec.len = 3'd2;
        end else begin
          dec.kind = otr_pkg::TK_AT;
        end
      end
      otr_pkg::CH_LT: begin
        if (has(e1, b1, otr_pkg::CH_EQ)) begin
          dec.kind = otr_pkg::TK_LT_EQ; dec.len = 3'd2;
        end else if (has(e1, b1, otr_pkg::CH_MINUS) && has(e2, b2, otr_pkg::CH_GT)) begin
          dec.kind = otr_pkg::TK_LT_DASH_GT; dec.len = 3'd3;
        end else if (!has(e1, b1, otr_pkg::CH_LT)) begin
          dec.kind = otr_pkg::TK_LT;
        end else if (has(e2, b2, otr_pkg::CH_LT)) begin
          if (has(e3, b3, otr_pkg::CH_EQ)) begin
            dec.kind = otr_pkg::TK_LT3_EQ; dec.len = 3'd4;
          end else begin
            dec.kind = otr_pkg::TK_LT3; dec.len = 3'd3;
          end
        end else if (has(e2, b2, otr_pkg::CH_EQ)) begin
          dec.kind = otr_pkg::TK_LT2_EQ; dec.len = 3'd3;
        end else begin
          dec.kind = otr_pkg::TK_LT2; dec.len = 3'd2;
        end
      end
      otr_pkg::CH_GT: begin
        if (has(e1, b1, otr_pkg::CH_EQ)) begin
          dec.kind = otr_pkg::TK_GT_EQ; dec.len = 3'd2;
        end else if (!has(e1, b1, otr_pkg::CH_GT)) begin
          dec.kind = otr_pkg::TK_GT;
        end else if (has(e2, b2, otr_pkg::CH_GT)) begin
          if (has(e3, b3, otr_pkg::CH_EQ)) begin
            dec.kind = otr_pkg::TK_GT3_EQ; dec.len = 3'd4;
          end else begin
            dec.kind = otr_pkg::TK_GT3; dec.len = 3'd3;
          end
        end else if (has(e2, b2, otr_pkg::CH_EQ)) begin
          dec.kind = otr_pkg::TK_GT2_EQ; dec.len = 3'd3;
        end else begin
          dec.kind = otr_pkg::TK_GT2; dec.len = 3'd2;
        end
      end
      default: begin
        dec.kind = otr_pkg::TK_ERROR;
        dec.len  = 3'd1;
      end
    endcase
  end

endmodule

>>> src/otr_checker.sv
// Checker: port-level properties of the operator token recognizer, bound to the top level.
module otr_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [6:0] token_kind,
  input logic [2:0] token_length
);

  // held token keeps its payload while stalled
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(token_kind) && $stable(token_length))
    else $error("token changed while stalled");

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> token_length >= 3'd1 && token_length <= 3'd4)
    else $error("token length out of range");

  a_err_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind == 7'(otr_pkg::TK_ERROR) |-> token_length == 3'd1)
    else $error("error token longer than one byte");

  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("token shown right after reset");

endmodule

bind operator_token_recognizer otr_checker u_otr_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (tok_out.valid),
  .out_ready    (tok_out.ready),
  .token_kind   (tok_out.token_kind),
  .token_length (tok_out.token_length)
);
